/* src/crc16_length_frame_deframer_assert.svh */
// Assertion macros used by the deframer parser.
`ifndef CRC16_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define CRC16_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define CRCFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crcfd: same-cycle check failed");
`define CRCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crcfd: next-cycle check failed");
`else
`define CRCFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CRCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/crcfd_pkg.sv */
package crcfd_pkg;

	localparam logic [2:0] EV_CMD    = 3'd0;
	localparam logic [2:0] EV_DATA   = 3'd1;
	localparam logic [2:0] EV_GOOD   = 3'd2;
	localparam logic [2:0] EV_CRCERR = 3'd3;
	localparam logic [2:0] EV_DROP   = 3'd4;

	localparam logic [1:0] REG_START_FIRST  = 2'd0;
	localparam logic [1:0] REG_START_SECOND = 2'd1;
	localparam logic [1:0] REG_CRC_INIT     = 2'd2;
	localparam logic [1:0] REG_IDLE_LIMIT   = 2'd3;

	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [15:0] IDLE_SATURATE  = 16'hffff;
	localparam logic [16:0] POS_CRC_HIGH_BASE = 17'd5;

	localparam logic [7:0]  START_FIRST_RST  = 8'd106;
	localparam logic [7:0]  START_SECOND_RST = 8'd1;
	localparam logic [15:0] CRC_INIT_RST     = 16'd0;
	localparam logic [15:0] IDLE_LIMIT_RST   = 16'd20;

	typedef struct packed {
		logic [7:0]  start_first;
		logic [7:0]  start_second;
		logic [15:0] crc_init;
		logic [15:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		logic        has_event;
		logic [2:0]  kind;
		logic [7:0]  byte_out;
		logic [7:0]  payload_length;
	} result_t;

	// CRC-16, polynomial 0x1021, MSB first, one byte per call.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* src/crcfd_if.sv */
interface crcfd_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface crcfd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] byte_out;
	logic [7:0] payload_length;

	modport source (output valid, output event_kind, output byte_out, output payload_length,
		input ready);
	modport sink (input valid, input event_kind, input byte_out, input payload_length,
		output ready);
endinterface

/* src/crc16_length_frame_deframer.sv */
// Length-prefixed frame deframer with CRC-16 check.
// The items channel carries one beat per received UART byte (cmd = 0) or per
// millisecond tick (cmd = 1). The events channel carries at most one beat per
// item: a command byte, a data byte, a good-frame or CRC-error marker, or a
// drop marker, each with the low byte of the declared length.
// An accepted item is registered in the parse stage, and its event is written
// to the output register when the parse stage fires, that is when the output
// register is empty or its event is being taken. One item can be accepted
// every cycle while the receiver does not stall; the rate is set by the
// single parse stage, which updates the frame state and the CRC by a whole
// byte at once. When the receiver stalls, the output register holds its
// event, the parse stage holds the next item and items.ready falls until
// space frees up. Reset clears both stages, returns the parser to hunting
// for a start byte and restores the register defaults. Registers are
// written through cfg_we, cfg_index and cfg_wdata; the user must write them
// only while no frame work is pending, as the block does not enforce it.
module crc16_length_frame_deframer #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	crcfd_in_if.sink             items,
	crcfd_out_if.source          events,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);

	crcfd_pkg::cfg_t    cfg_q;
	crcfd_pkg::result_t res;

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       fire;

	logic       ev_valid_q;
	logic [2:0] ev_kind_q;
	logic [7:0] ev_byte_q;
	logic [7:0] ev_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first  <= crcfd_pkg::START_FIRST_RST;
			cfg_q.start_second <= crcfd_pkg::START_SECOND_RST;
			cfg_q.crc_init     <= crcfd_pkg::CRC_INIT_RST;
			cfg_q.idle_limit   <= crcfd_pkg::IDLE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				crcfd_pkg::REG_START_FIRST:  cfg_q.start_first  <= cfg_wdata[7:0];
				crcfd_pkg::REG_START_SECOND: cfg_q.start_second <= cfg_wdata[7:0];
				crcfd_pkg::REG_CRC_INIT:     cfg_q.crc_init     <= cfg_wdata;
				crcfd_pkg::REG_IDLE_LIMIT:   cfg_q.idle_limit   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The parse stage moves only when the output register can take a beat.
	assign fire        = valid_s1 && (!ev_valid_q || events.ready);
	assign items.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_s1  <= items.cmd;
			byte_s1 <= items.data_byte;
		end
	end

	crcfd_parser #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (fire && res.has_event) begin
			ev_valid_q <= 1'b1;
		end else if (events.ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.has_event) begin
			ev_kind_q <= res.kind;
			ev_byte_q <= res.byte_out;
			ev_len_q  <= res.payload_length;
		end
	end

	assign events.valid          = ev_valid_q;
	assign events.event_kind     = ev_kind_q;
	assign events.byte_out       = ev_byte_q;
	assign events.payload_length = ev_len_q;

endmodule

/* src/crcfd_parser.sv */
`include "crc16_length_frame_deframer_assert.svh"

module crcfd_parser #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                cmd,
	input  logic [7:0]          data_byte,
	input  crcfd_pkg::cfg_t     cfg,
	output crcfd_pkg::result_t  res
);

	localparam int PW = $clog2(MAX_FRAME_BYTES);
	localparam int CW = 17;
	localparam logic [PW:0] MAX_POS = (PW + 1)'(MAX_FRAME_BYTES);
	localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

	logic [PW-1:0] pos_q, pos_d;
	logic [15:0]   len_q, len_d;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    crch_q, crch_d;
	logic [15:0]   idle_q, idle_d;

	logic [15:0]   crc_upd;
	logic [15:0]   idle_inc;
	logic [CW-1:0] pos_w;
	logic [CW-1:0] crc_hi_pos;
	logic [PW:0]   nxt;
	logic          drop_now;
	logic          frame_end;
	logic          ev_data_fire;
	logic          ev_end_fire;

	assign crc_upd    = crcfd_pkg::crc_feed((pos_q == '0) ? cfg.crc_init : crc_q, data_byte);
	assign idle_inc   = (idle_q == crcfd_pkg::IDLE_SATURATE) ? idle_q : idle_q + 16'd1;
	assign pos_w      = {{(CW - PW){1'b0}}, pos_q};
	assign crc_hi_pos = {1'b0, len_q} + crcfd_pkg::POS_CRC_HIGH_BASE;

	always_comb begin
		pos_d  = pos_q;
		len_d  = len_q;
		crc_d  = crc_q;
		crch_d = crch_q;
		idle_d = idle_q;
		nxt    = {1'b0, pos_q};
		drop_now  = 1'b0;
		frame_end = 1'b0;
		res.has_event = 1'b0;
		res.kind      = crcfd_pkg::EV_CMD;
		res.byte_out  = 8'h00;

		if (cmd) begin
			idle_d = idle_inc;
			if (idle_inc == cfg.idle_limit && pos_q != '0) begin
				pos_d = '0;
				res.has_event = 1'b1;
				res.kind      = crcfd_pkg::EV_DROP;
			end
		end else begin
			idle_d = '0;
			if (pos_q == PW'(0)) begin
				if (data_byte == cfg.start_first) begin
					crc_d = crc_upd;
					nxt   = (PW + 1)'(1);
				end
			end else if (pos_q == PW'(1)) begin
				if (data_byte == cfg.start_second) begin
					crc_d = crc_upd;
					nxt   = (PW + 1)'(2);
				end else begin
					nxt = '0;
				end
			end else if (pos_q == PW'(2)) begin
				len_d = {data_byte, 8'h00};
				crc_d = crc_upd;
				nxt   = (PW + 1)'(3);
			end else if (pos_q == PW'(3)) begin
				len_d = {len_q[15:8], data_byte};
				crc_d = crc_upd;
				if (len_d < MAX_LEN) begin
					nxt = (PW + 1)'(4);
				end else begin
					drop_now = 1'b1;
				end
			end else if (pos_q == PW'(4)) begin
				crc_d = crc_upd;
				nxt   = (PW + 1)'(5);
				res.has_event = 1'b1;
				res.kind      = crcfd_pkg::EV_CMD;
				res.byte_out  = data_byte;
			end else if (pos_w < crc_hi_pos) begin
				crc_d = crc_upd;
				nxt   = {1'b0, pos_q} + (PW + 1)'(1);
				res.has_event = 1'b1;
				res.kind      = crcfd_pkg::EV_DATA;
				res.byte_out  = data_byte;
			end else if (pos_w == crc_hi_pos) begin
				crch_d = data_byte;
				nxt    = {1'b0, pos_q} + (PW + 1)'(1);
			end else if (pos_w == crc_hi_pos + 17'd1) begin
				frame_end = 1'b1;
				res.has_event = 1'b1;
				res.kind = ({crch_q, data_byte} == crc_q) ? crcfd_pkg::EV_GOOD
					: crcfd_pkg::EV_CRCERR;
			end else begin
				nxt = '0;
			end

			if (frame_end) begin
				pos_d = '0;
			end else if (drop_now || nxt >= MAX_POS) begin
				// An overflowing byte or an oversized length reports a drop in place of its own event.
				pos_d = '0;
				res.has_event = 1'b1;
				res.kind      = crcfd_pkg::EV_DROP;
				res.byte_out  = 8'h00;
			end else begin
				pos_d = nxt[PW-1:0];
			end
		end
		res.payload_length = len_d[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			crc_q  <= crcfd_pkg::CRC_INIT_RST;
			crch_q <= '0;
			idle_q <= '0;
		end else if (fire) begin
			pos_q  <= pos_d;
			len_q  <= len_d;
			crc_q  <= crc_d;
			crch_q <= crch_d;
			idle_q <= idle_d;
		end
	end

	assign ev_data_fire = fire && res.has_event && res.kind == crcfd_pkg::EV_DATA;
	assign ev_end_fire  = fire && res.has_event && res.kind != crcfd_pkg::EV_CMD
		&& res.kind != crcfd_pkg::EV_DATA;

	`CRCFD_ASSERT_IMPL(a_len_in_range, clk, arst_n, pos_q >= PW'(4), len_q < MAX_LEN)
	`CRCFD_ASSERT_IMPL(a_data_after_cmd, clk, arst_n, ev_data_fire, pos_q >= PW'(5))
	`CRCFD_ASSERT_NEXT(a_end_rehunts, clk, arst_n, ev_end_fire, pos_q == '0)

endmodule

/* verif/crc16_length_frame_deframer_tb.sv */
`timescale 1ns / 100ps

module crc16_length_frame_deframer_tb;

	localparam int FRAME_LIMIT = 256;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 160;
	localparam int DIRECTED_ROWS = 27;

	// Frame byte positions as the parser counts them.
	localparam int POS_HUNT = 0;
	localparam int POS_START2 = 1;
	localparam int POS_LEN_HI = 2;
	localparam int POS_LEN_LO = 3;
	localparam int POS_CMD = 4;
	localparam int CRC_HI_OFFSET = 5;
	localparam int CRC_LO_OFFSET = 6;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] byte_out;
		logic [7:0] payload_length;
	} frame_event_t;

	typedef enum logic [2:0] {ROW_BYTE, ROW_TICK, ROW_CRC_HI, ROW_CRC_HI_BAD, ROW_CRC_LO} row_src_e;
	typedef enum logic {WANT_NONE, WANT_EVENT} row_want_e;

	typedef struct packed {
		row_src_e     src;
		logic [7:0]   value;
		row_want_e    want;
		frame_event_t ev;
	} directed_row_t;

	typedef enum logic [1:0] {FLAW_NONE, FLAW_BAD_CRC, FLAW_BAD_START2, FLAW_TRUNCATED} frame_flaw_e;

	typedef struct packed {
		logic [7:0]  start_first;
		logic [7:0]  start_second;
		logic [15:0] crc_init;
		logic [15:0] idle_limit;
	} phase_cfg_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	crcfd_in_if  item_ch ();
	crcfd_out_if event_ch ();

	crc16_length_frame_deframer #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.events(event_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Register copies and parser state of the predictor.
	logic [7:0]  cfg_start_first = crcfd_pkg::START_FIRST_RST;
	logic [7:0]  cfg_start_second = crcfd_pkg::START_SECOND_RST;
	logic [15:0] cfg_crc_init = crcfd_pkg::CRC_INIT_RST;
	logic [15:0] cfg_idle_limit = crcfd_pkg::IDLE_LIMIT_RST;

	int          parse_pos = POS_HUNT;
	logic [15:0] frame_len = '0;
	logic [15:0] frame_crc = crcfd_pkg::CRC_INIT_RST;
	logic [7:0]  crc_high_seen = '0;
	logic [15:0] idle_count = '0;

	frame_event_t pending_events[$];

	int  items_sent = 0;
	int  events_checked = 0;
	int  good_seen = 0;
	int  crcerr_seen = 0;
	int  drop_seen = 0;
	int  fail_count = 0;
	bit  send_quiet = 1'b0;
	bit  recv_quiet = 1'b0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_TICK,       8'h00, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h00, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h6a, WANT_NONE,  '0},
		// A repeated first start byte in second place sends the parser back to hunting.
		'{ROW_BYTE,       8'h6a, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h6a, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h01, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h00, WANT_NONE,  '0},
		'{ROW_TICK,       8'h00, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h01, WANT_NONE,  '0},
		'{ROW_BYTE,       8'hff, WANT_EVENT, '{crcfd_pkg::EV_CMD, 8'hff, 8'h01}},
		'{ROW_BYTE,       8'h00, WANT_EVENT, '{crcfd_pkg::EV_DATA, 8'h00, 8'h01}},
		'{ROW_CRC_HI,     8'h00, WANT_NONE,  '0},
		'{ROW_CRC_LO,     8'h00, WANT_EVENT, '{crcfd_pkg::EV_GOOD, 8'h00, 8'h01}},
		'{ROW_BYTE,       8'h6a, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h01, WANT_NONE,  '0},
		'{ROW_BYTE,       8'hff, WANT_NONE,  '0},
		'{ROW_BYTE,       8'hff, WANT_EVENT, '{crcfd_pkg::EV_DROP, 8'h00, 8'hff}},
		'{ROW_BYTE,       8'h6a, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h01, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h00, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h00, WANT_NONE,  '0},
		'{ROW_BYTE,       8'h7e, WANT_EVENT, '{crcfd_pkg::EV_CMD, 8'h7e, 8'h00}},
		'{ROW_CRC_HI_BAD, 8'h00, WANT_NONE,  '0},
		'{ROW_CRC_LO,     8'h00, WANT_EVENT, '{crcfd_pkg::EV_CRCERR, 8'h00, 8'h00}},
		// The idle limit is two here, so the second tick times the frame out.
		'{ROW_BYTE,       8'h6a, WANT_NONE,  '0},
		'{ROW_TICK,       8'h00, WANT_NONE,  '0},
		'{ROW_TICK,       8'h00, WANT_EVENT, '{crcfd_pkg::EV_DROP, 8'h00, 8'h00}}
	};

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[15] ^ b[i];
			r = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ crcfd_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	// Advances the predicted parser by one item; returns 1 when it yields an event.
	function automatic bit parse_item(input logic is_tick, input logic [7:0] b,
		output frame_event_t ev);
		int nxt;
		bit has_ev;
		ev = '0;
		has_ev = 1'b0;
		if (is_tick) begin
			if (idle_count != crcfd_pkg::IDLE_SATURATE) begin
				idle_count++;
			end
			if (idle_count == cfg_idle_limit && parse_pos != POS_HUNT) begin
				parse_pos = POS_HUNT;
				ev.kind = crcfd_pkg::EV_DROP;
				ev.payload_length = frame_len[7:0];
				return 1'b1;
			end
			return 1'b0;
		end
		idle_count = '0;
		nxt = parse_pos;
		if (parse_pos == POS_HUNT) begin
			if (b == cfg_start_first) begin
				frame_crc = crc16_step(cfg_crc_init, b);
				nxt = POS_START2;
			end
		end else if (parse_pos == POS_START2) begin
			if (b == cfg_start_second) begin
				frame_crc = crc16_step(frame_crc, b);
				nxt = POS_LEN_HI;
			end else begin
				nxt = POS_HUNT;
			end
		end else if (parse_pos == POS_LEN_HI) begin
			frame_len = {b, 8'h00};
			frame_crc = crc16_step(frame_crc, b);
			nxt = POS_LEN_LO;
		end else if (parse_pos == POS_LEN_LO) begin
			frame_len[7:0] = b;
			frame_crc = crc16_step(frame_crc, b);
			if (frame_len >= FRAME_LIMIT) begin
				parse_pos = POS_HUNT;
				ev.kind = crcfd_pkg::EV_DROP;
				ev.payload_length = b;
				return 1'b1;
			end
			nxt = POS_CMD;
		end else if (parse_pos == POS_CMD) begin
			frame_crc = crc16_step(frame_crc, b);
			ev.kind = crcfd_pkg::EV_CMD;
			ev.byte_out = b;
			has_ev = 1'b1;
			nxt = POS_CMD + 1;
		end else if (parse_pos < CRC_HI_OFFSET + frame_len) begin
			frame_crc = crc16_step(frame_crc, b);
			ev.kind = crcfd_pkg::EV_DATA;
			ev.byte_out = b;
			has_ev = 1'b1;
			nxt = parse_pos + 1;
		end else if (parse_pos == CRC_HI_OFFSET + frame_len) begin
			crc_high_seen = b;
			nxt = parse_pos + 1;
		end else if (parse_pos == CRC_LO_OFFSET + frame_len) begin
			parse_pos = POS_HUNT;
			ev.kind = ({crc_high_seen, b} == frame_crc) ? crcfd_pkg::EV_GOOD
				: crcfd_pkg::EV_CRCERR;
			ev.payload_length = frame_len[7:0];
			return 1'b1;
		end else begin
			nxt = POS_HUNT;
		end
		// A byte that would run past the buffer drops the frame instead of its own event.
		if (nxt >= FRAME_LIMIT) begin
			parse_pos = POS_HUNT;
			ev.kind = crcfd_pkg::EV_DROP;
			ev.byte_out = 8'h00;
			ev.payload_length = frame_len[7:0];
			return 1'b1;
		end
		parse_pos = nxt;
		ev.payload_length = frame_len[7:0];
		return has_ev;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("crc16_length_frame_deframer verification failed");
		$finish;
	end

	// Event side: checks every accepted beat and stalls at random between beats.
	initial begin : event_sink
		int hold;
		frame_event_t want;
		hold = 0;
		event_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && event_ch.valid && event_ch.ready) begin
				events_checked++;
				if (event_ch.event_kind == crcfd_pkg::EV_GOOD) good_seen++;
				if (event_ch.event_kind == crcfd_pkg::EV_CRCERR) crcerr_seen++;
				if (event_ch.event_kind == crcfd_pkg::EV_DROP) drop_seen++;
				if (pending_events.size() == 0) begin
					$error("unexpected event: kind %0d, byte_out %0h, payload_length %0h",
						event_ch.event_kind, event_ch.byte_out, event_ch.payload_length);
					fail_count++;
				end else begin
					want = pending_events.pop_front();
					if (event_ch.event_kind !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, event_ch.event_kind);
						fail_count++;
					end
					if (event_ch.byte_out !== want.byte_out) begin
						$error("byte_out: expected %0h, got %0h", want.byte_out, event_ch.byte_out);
						fail_count++;
					end
					if (event_ch.payload_length !== want.payload_length) begin
						$error("payload_length: expected %0h, got %0h", want.payload_length,
							event_ch.payload_length);
						fail_count++;
					end
				end
				hold = recv_quiet ? 0 : $urandom_range(0, 11);
			end
			if (!arst_n) begin
				event_ch.ready <= 1'b0;
			end else if (hold != 0) begin
				hold--;
				event_ch.ready <= 1'b0;
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	task automatic drive_item(input logic is_tick, input logic [7:0] b, output bit has_ev,
		output frame_event_t ev);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= is_tick;
		item_ch.data_byte <= is_tick ? 8'($urandom) : b;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		has_ev = parse_item(is_tick, b, ev);
	endtask

	task automatic send_byte(input logic [7:0] b);
		bit has_ev;
		frame_event_t ev;
		drive_item(1'b0, b, has_ev, ev);
		if (has_ev) pending_events.push_back(ev);
	endtask

	task automatic send_ticks(input int n);
		bit has_ev;
		frame_event_t ev;
		repeat (n) begin
			drive_item(1'b1, 8'h00, has_ev, ev);
			if (has_ev) pending_events.push_back(ev);
		end
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			crcfd_pkg::REG_START_FIRST: cfg_start_first = val[7:0];
			crcfd_pkg::REG_START_SECOND: cfg_start_second = val[7:0];
			crcfd_pkg::REG_CRC_INIT: cfg_crc_init = val;
			crcfd_pkg::REG_IDLE_LIMIT: cfg_idle_limit = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// The upper byte of an 8-bit register write is noise and must be ignored.
	task automatic apply_config(input phase_cfg_t c);
		write_reg(crcfd_pkg::REG_START_FIRST, {8'($urandom), c.start_first});
		write_reg(crcfd_pkg::REG_START_SECOND, {8'($urandom), c.start_second});
		write_reg(crcfd_pkg::REG_CRC_INIT, c.crc_init);
		write_reg(crcfd_pkg::REG_IDLE_LIMIT, c.idle_limit);
	endtask

	task automatic send_frame(input logic [15:0] len, input frame_flaw_e flaw);
		logic [7:0]  frame_bytes[$];
		logic [15:0] crc;
		int          body;
		while (parse_pos != POS_HUNT) send_byte(8'($urandom));
		body = (len < FRAME_LIMIT) ? int'(len) + 1 : 0;
		frame_bytes = {cfg_start_first, cfg_start_second, len[15:8], len[7:0]};
		repeat (body) frame_bytes.push_back(8'($urandom));
		if (body != 0) begin
			crc = cfg_crc_init;
			foreach (frame_bytes[i]) crc = crc16_step(crc, frame_bytes[i]);
			frame_bytes.push_back(crc[15:8]);
			frame_bytes.push_back(crc[7:0]);
		end
		case (flaw)
			FLAW_BAD_CRC: begin
				if (body != 0) begin
					frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 1)] ^=
						8'($urandom_range(1, 255));
				end
			end
			FLAW_BAD_START2: begin
				frame_bytes[1] = cfg_start_second ^ 8'($urandom_range(1, 255));
				frame_bytes = frame_bytes[0:$urandom_range(1, 3)];
			end
			FLAW_TRUNCATED: frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
			default: ;
		endcase
		foreach (frame_bytes[i]) begin
			if (i != 0 && $urandom_range(0, 24) == 0) send_ticks($urandom_range(1, 3));
			send_byte(frame_bytes[i]);
		end
		if (flaw == FLAW_TRUNCATED && cfg_idle_limit <= 40) send_ticks(int'(cfg_idle_limit));
	endtask

	task automatic run_phase(input int count);
		int start_count;
		int pick;
		int tick_cap;
		bit paused;
		logic [15:0] len;
		frame_flaw_e flaw;
		start_count = items_sent;
		paused = 1'b0;
		tick_cap = (cfg_idle_limit < 30) ? int'(cfg_idle_limit) + 2 : 30;
		while (items_sent - start_count < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				pick = $urandom_range(0, 99);
				if (pick < 90) len = 16'($urandom_range(0, 12));
				else if (pick < 97) len = 16'($urandom_range(13, 64));
				else len = {8'($urandom_range(1, 255)), 8'($urandom)};
				pick = $urandom_range(0, 99);
				if (pick < 75) flaw = FLAW_NONE;
				else if (pick < 87) flaw = FLAW_BAD_CRC;
				else if (pick < 94) flaw = FLAW_BAD_START2;
				else flaw = FLAW_TRUNCATED;
				send_frame(len, flaw);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(($urandom_range(0, 5) == 0) ? cfg_start_first : 8'($urandom));
				end
			end else begin
				send_ticks($urandom_range(1, tick_cap));
			end
			if ($urandom_range(0, 9) == 0) send_quiet = !send_quiet;
			if ($urandom_range(0, 9) == 0) recv_quiet = !recv_quiet;
			// Hold the sender once until every outstanding event has been drained.
			if (!paused && items_sent - start_count >= count / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin : stimulus
		phase_cfg_t   phase_plan [PHASES];
		directed_row_t row;
		logic [7:0]   b;
		bit           has_ev;
		frame_event_t ev;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = crcfd_pkg::REG_START_FIRST;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = 1'b0;
		item_ch.data_byte = '0;

		phase_plan[0] = '{crcfd_pkg::START_FIRST_RST, crcfd_pkg::START_SECOND_RST,
			crcfd_pkg::CRC_INIT_RST, crcfd_pkg::IDLE_LIMIT_RST};
		phase_plan[1] = '{8'h00, 8'hff, 16'hffff, 16'd1};
		phase_plan[2] = '{8'hff, 8'h00, 16'h1d0f, crcfd_pkg::IDLE_SATURATE};
		phase_plan[3] = '{8'h55, 8'h55, 16'($urandom), 16'd3};
		phase_plan[4] = '{8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom_range(1, 40))};
		phase_plan[5] = '{8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom_range(4, 12))};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Start bytes and CRC seed stay at their reset values for the directed rows.
		write_reg(crcfd_pkg::REG_IDLE_LIMIT, 16'd2);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.src)
				ROW_CRC_HI: b = frame_crc[15:8];
				ROW_CRC_HI_BAD: b = ~frame_crc[15:8];
				ROW_CRC_LO: b = frame_crc[7:0];
				default: b = row.value;
			endcase
			drive_item(row.src == ROW_TICK, b, has_ev, ev);
			if (row.want == WANT_EVENT) pending_events.push_back(row.ev);
			else if (has_ev) pending_events.push_back(ev);
		end
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			recv_quiet = ($urandom_range(0, 3) == 0);
			apply_config(phase_plan[p]);
			if (p == 0) begin
				// Longest legal frame, then overflow at the CRC and within the data.
				send_frame(16'd249, FLAW_NONE);
				send_frame(16'd250, FLAW_NONE);
				send_frame(16'd253, FLAW_NONE);
			end
			run_phase(PHASE_ITEMS);
			wait_drained();
		end

		$display("Sent %0d items over %0d register settings; checked %0d events.",
			items_sent, PHASES + 1, events_checked);
		$display("Frames ended good %0d, with CRC error %0d, dropped %0d.",
			good_seen, crcerr_seen, drop_seen);
		if (fail_count == 0 && pending_events.size() == 0) begin
			$display("crc16_length_frame_deframer verification clean");
		end else begin
			$display("crc16_length_frame_deframer verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/crcfd_pkg.sv
src/crcfd_if.sv
src/crcfd_parser.sv
src/crc16_length_frame_deframer.sv
verif/crc16_length_frame_deframer_tb.sv
